[sv/hvt_pkg.sv]
// Shared constants, types and reset values for the homogeneous vertex transform.
`default_nettype none

package hvt_pkg;

    // Field and number format.
    localparam int FLD_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;

    // Configuration port.
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    // Datapath widths.
    localparam int LANES  = 3;
    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = 2 * COORD_W + 1;
    localparam int MAG_W  = SUM_W;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int QB     = COORD_W;
    localparam int HI_W   = NUM_W - QB;
    localparam int CMP_W  = (HI_W > MAG_W) ? HI_W : MAG_W;
    localparam int STEPS  = QB;

    // Register reset values: identity matrix.
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + 32);
    localparam logic [CFG_W-1:0] MTX_RST [NUM_REGS] = '{
        ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
    };

    // Matrix entries, row by column, each a signed coefficient.
    typedef logic [3:0][3:0][COORD_W-1:0] t_mtx;

    // Column sums handed from the dot-product stages to the divider.
    typedef struct packed {
        logic                  valid;
        logic [3:0][SUM_W-1:0] sum;
    } t_dot;

    // One divider stage: partial remainder and numerator/quotient shift word per lane.
    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] rem;
        logic [LANES-1:0][QB-1:0]    nq;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            ovf;
        logic [MAG_W-1:0]            den;
        logic                        wz;
    } t_dstg;

    // Finished result.
    typedef struct packed {
        logic                        valid;
        logic [LANES-1:0][FLD_W-1:0] coord;
        logic                        w_zero;
        logic                        saturated;
    } t_res;

endpackage

`default_nettype wire

[sv/hvt_if.sv]
// Channel interfaces: vertex requests, result requests and register writes.
`default_nettype none

interface hvt_vtx_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;

    modport source(output valid, vertex_x, vertex_y, vertex_z, input ready);
    modport sink(input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface hvt_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        w_zero;
    logic        saturated;

    modport source(output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
    modport sink(input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface

interface hvt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/hvt_mat_regs.sv]
// Matrix register file written through the configuration channel.
`default_nettype none

module hvt_mat_regs (
    input  wire            i_clk,
    input  wire            i_rst_n,
    hvt_cfg_if.sink        i_cfg,
    output hvt_pkg::t_mtx  o_mtx
);
    import hvt_pkg::*;

    logic [CFG_W-1:0] r_regs [NUM_REGS];
    logic             w_wr;

    // Writes are always taken; an index past the last register is dropped.
    assign i_cfg.ready = 1'b1;
    assign w_wr = i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_regs[k] <= MTX_RST[k];
            end
        end else if (w_wr) begin
            r_regs[i_cfg.index[REG_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    // Each register holds two entries of one row: even column low, odd column high.
    for (genvar row = 0; row < 4; row++) begin : g_row
        for (genvar col = 0; col < 4; col++) begin : g_col
            assign o_mtx[row][col] = r_regs[row * 2 + col / 2][(col % 2) * 32 +: COORD_W];
        end
    end

endmodule

`default_nettype wire

[sv/hvt_dot.sv]
// Two pipeline stages: twelve coefficient products, then the four column sums.
`default_nettype none

module hvt_dot (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_en,
    input  wire                                      i_valid,
    input  wire [2:0][hvt_pkg::FLD_W-1:0]            i_vtx,
    input  hvt_pkg::t_mtx                            i_mtx,
    output hvt_pkg::t_dot                            o_dot
);
    import hvt_pkg::*;

    logic signed [COORD_W-1:0] w_v   [LANES];
    logic signed [PROD_W-1:0]  r_prod [LANES][4];
    logic                      r_v1;
    logic                      r_v2;
    logic [3:0][SUM_W-1:0]     r_sum;
    logic signed [SUM_W-1:0]   n_sum [4];

    // Only the low coordinate bits count, taken as signed.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_v[i] = $signed(i_vtx[i][COORD_W-1:0]);
        end
    end

    // Valid bits follow the data through both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: one multiplier per coefficient of the first three rows.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= w_v[i] * $signed(i_mtx[i][j]);
                end
            end
        end
    end

    // Stage two: products plus the translation row scaled to the product format.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_sum[j] = SUM_W'(r_prod[0][j]) + SUM_W'(r_prod[1][j]) + SUM_W'(r_prod[2][j])
                     + (SUM_W'($signed(i_mtx[3][j])) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= n_sum[j];
            end
        end
    end

    assign o_dot.valid = r_v2;
    assign o_dot.sum   = r_sum;

endmodule

`default_nettype wire

[sv/hvt_div.sv]
// Perspective divide: magnitude stage, setup stage, one quotient bit per stage, output stage.
`default_nettype none

module hvt_div (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_en,
    input  hvt_pkg::t_dot  i_dot,
    output hvt_pkg::t_res  o_res
);
    import hvt_pkg::*;

    localparam logic [QB-1:0] LIM_POS = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {1'b1, {(QB-1){1'b0}}};

    logic                     r_a_valid;
    logic [3:0][MAG_W-1:0]    r_a_mag;
    logic [LANES-1:0]         r_a_neg;
    logic                     r_a_wz;
    logic [3:0][MAG_W-1:0]    n_a_mag;
    logic [LANES-1:0]         n_a_neg;
    t_dstg                    n_b;
    t_dstg                    r_stg [0:STEPS];
    logic [STEPS:0]           r_sv;
    t_res                     r_res;
    t_res                     n_res;

    // One restoring step: shift in the next numerator bit, subtract when it fits.
    function automatic t_dstg div_step(input t_dstg s);
        t_dstg            r;
        logic [MAG_W:0]   t;
        logic [MAG_W:0]   diff;
        logic             ge;
        r = s;
        for (int l = 0; l < LANES; l++) begin
            t        = {s.rem[l], s.nq[l][QB-1]};
            diff     = t - {1'b0, s.den};
            ge       = (t >= {1'b0, s.den});
            r.rem[l] = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
            r.nq[l]  = {s.nq[l][QB-2:0], ge};
        end
        return r;
    endfunction

    // Valid bits for every stage, and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sv      <= '0;
            r_res     <= '0;
        end else if (i_en) begin
            r_a_valid <= i_dot.valid;
            r_sv      <= {r_sv[STEPS-1:0], r_a_valid};
            r_res     <= n_res;
        end
    end

    // Magnitudes and result signs.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_a_mag[j] = i_dot.sum[j][SUM_W-1] ? MAG_W'(-i_dot.sum[j]) : i_dot.sum[j];
        end
        for (int l = 0; l < LANES; l++) begin
            n_a_neg[l] = i_dot.sum[l][SUM_W-1] ^ i_dot.sum[3][SUM_W-1];
        end
    end

    // Setup: a high numerator part at or above the divisor means the quotient is too large.
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [HI_W-1:0]  hi;
        n_b     = '0;
        n_b.den = r_a_mag[3];
        n_b.wz  = r_a_wz;
        n_b.neg = r_a_neg;
        for (int l = 0; l < LANES; l++) begin
            num        = NUM_W'(r_a_mag[l]) << FRAC_BITS;
            hi         = num[NUM_W-1:QB];
            n_b.ovf[l] = CMP_W'(hi) >= CMP_W'(r_a_mag[3]);
            n_b.rem[l] = n_b.ovf[l] ? '0 : MAG_W'(hi);
            n_b.nq[l]  = num[QB-1:0];
        end
    end

    // Output: clip to the coordinate range, apply the sign, zero everything for w of zero.
    always_comb begin
        logic [QB-1:0] q;
        logic [QB-1:0] mag;
        logic [QB-1:0] val;
        logic          sat;
        n_res           = '0;
        n_res.valid     = r_sv[STEPS];
        n_res.w_zero    = r_stg[STEPS].wz;
        for (int l = 0; l < LANES; l++) begin
            q   = r_stg[STEPS].nq[l];
            sat = r_stg[STEPS].ovf[l]
                | (q[QB-1] & (!r_stg[STEPS].neg[l] | (q[QB-2:0] != '0)));
            mag = sat ? (r_stg[STEPS].neg[l] ? LIM_NEG : LIM_POS) : q;
            val = r_stg[STEPS].neg[l] ? -mag : mag;
            if (!r_stg[STEPS].wz) begin
                n_res.coord[l]  = FLD_W'($signed(val));
                n_res.saturated = n_res.saturated | sat;
            end
        end
    end

    // Payload registers of the magnitude and divider stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= n_a_mag;
            r_a_neg <= n_a_neg;
            r_a_wz  <= (i_dot.sum[3] == '0);
            r_stg[0] <= n_b;
            for (int k = 0; k < STEPS; k++) begin
                r_stg[k+1] <= div_step(r_stg[k]);
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[sv/homogeneous_vertex_transform_top.sv]
// The 32 divider stages, one quotient bit each, set the pipeline depth.
// Throughput: one vertex per cycle while the output is empty or taken.
// The whole pipeline, output register included, advances whenever the output is empty or taken.
// Reset (synchronous, active low) clears all valid bits and loads the identity matrix.
// Register writes are taken in the cycle they arrive.
`default_nettype none

module homogeneous_vertex_transform_top (
    input  wire     i_clk,
    input  wire     i_rst_n,
    hvt_vtx_if.sink   i_vtx,
    hvt_cfg_if.sink   i_cfg,
    hvt_res_if.source o_res
);
    import hvt_pkg::*;

    t_mtx                  w_mtx;
    t_dot                  w_dot;
    t_res                  w_res;
    logic                  w_en;
    logic [2:0][FLD_W-1:0] w_vtx;

    // Pipeline advances unless a finished result is held by the consumer.
    assign w_en        = !w_res.valid || o_res.ready;
    assign i_vtx.ready = w_en;
    assign w_vtx       = {i_vtx.vertex_z, i_vtx.vertex_y, i_vtx.vertex_x};

    hvt_mat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_mtx   (w_mtx)
    );

    hvt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_vtx.valid),
        .i_vtx   (w_vtx),
        .i_mtx   (w_mtx),
        .o_dot   (w_dot)
    );

    hvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_dot   (w_dot),
        .o_res   (w_res)
    );

    // Result channel.
    assign o_res.valid     = w_res.valid;
    assign o_res.out_x     = w_res.coord[0];
    assign o_res.out_y     = w_res.coord[1];
    assign o_res.out_z     = w_res.coord[2];
    assign o_res.w_zero    = w_res.w_zero;
    assign o_res.saturated = w_res.saturated;

`ifndef ASSERT_OFF
    // A zero w forces all coordinates and the clip flag to zero.
    a_wzero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.w_zero |->
            o_res.out_x == 0 && o_res.out_y == 0 && o_res.out_z == 0 && !o_res.saturated)
        else $error("w_zero result carries nonzero data");

    // A held result freezes the pipeline, so no new vertex is taken.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_vtx.ready)
        else $error("vertex accepted while output stalled");

    // Nothing comes out right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the homogeneous 4x4 vertex transform.
`timescale 1ns / 100ps

module tb_top;
    import hvt_pkg::*;

    // One transformed vertex as it leaves the block.
    typedef struct {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
        logic               saturated;
    } t_vertex_result;

    // Holds the matrix and the transformed vertices still owed by the block.
    class transform_scoreboard;
        logic [63:0]    mtx_regs [NUM_REGS];
        t_vertex_result pending [$];

        function new();
            for (int i = 0; i < NUM_REGS; i++) begin
                mtx_regs[i] = MTX_RST[i];
            end
        endfunction

        function void write_reg(logic [7:0] idx, logic [63:0] value);
            if (idx < NUM_REGS) begin
                mtx_regs[idx] = value;
            end
        endfunction

        function logic signed [31:0] coef(int row, int col);
            logic [63:0] r;
            r = mtx_regs[row * 2 + col / 2];
            return (col % 2) ? r[63:32] : r[31:0];
        endfunction

        // Computes the transformed vertex and queues it.
        function void note_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
            logic signed [127:0] col_sum [4];
            logic signed [127:0] term;
            logic signed [31:0]  vin [3];
            logic [127:0]        num_mag, den_mag, quot;
            logic [31:0]         mag;
            logic                neg, den_neg, sat;
            t_vertex_result      r;
            vin[0] = x;
            vin[1] = y;
            vin[2] = z;
            for (int j = 0; j < 4; j++) begin
                col_sum[j] = coef(3, j);
                col_sum[j] = col_sum[j] <<< FRAC_BITS;
                for (int i = 0; i < 3; i++) begin
                    term = vin[i];
                    term = term * coef(i, j);
                    col_sum[j] = col_sum[j] + term;
                end
            end
            r = '{0, 0, 0, 1'b0, 1'b0};
            if (col_sum[3] == 0) begin
                r.w_zero = 1'b1;
            end else begin
                den_neg = col_sum[3] < 0;
                den_mag = den_neg ? -col_sum[3] : col_sum[3];
                sat = 1'b0;
                for (int j = 0; j < 3; j++) begin
                    neg = (col_sum[j] < 0) != den_neg;
                    num_mag = (col_sum[j] < 0) ? -col_sum[j] : col_sum[j];
                    quot = (num_mag << FRAC_BITS) / den_mag;
                    if (quot > 128'h7fff_ffff + neg) begin
                        sat = 1'b1;
                        mag = 32'h7fff_ffff + neg;
                    end else begin
                        mag = quot[31:0];
                    end
                    if (j == 0) r.out_x = neg ? -mag : mag;
                    if (j == 1) r.out_y = neg ? -mag : mag;
                    if (j == 2) r.out_z = neg ? -mag : mag;
                end
                r.saturated = sat;
            end
            pending.push_back(r);
        endfunction

        // Returns an empty string on a match, otherwise a description.
        function string check_result(t_vertex_result got);
            t_vertex_result exp_r;
            if (pending.size() == 0) begin
                return "result request with no vertex outstanding";
            end
            exp_r = pending.pop_front();
            if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
                got.out_z !== exp_r.out_z || got.w_zero !== exp_r.w_zero ||
                got.saturated !== exp_r.saturated) begin
                return $sformatf("got %h %h %h wz=%b sat=%b, expected %h %h %h wz=%b sat=%b",
                    got.out_x, got.out_y, got.out_z, got.w_zero, got.saturated,
                    exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.w_zero, exp_r.saturated);
            end
            return "";
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hvt_vtx_if vtx ();
    hvt_cfg_if cfg ();
    hvt_res_if res ();

    homogeneous_vertex_transform_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .i_cfg   (cfg.sink),
        .o_res   (res.source)
    );

    transform_scoreboard sb;
    int  mismatches;
    int  cycle_count;
    int  send_gap_pct;
    int  recv_stall_pct;

    localparam int LATENCY     = 37;
    localparam int CYCLE_LIMIT = 300000;

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each accepted request, then stall at random.
    always @(posedge i_clk) begin
        t_vertex_result got;
        string          msg;
        if (i_rst_n && res.valid && res.ready) begin
            got = '{res.out_x, res.out_y, res.out_z, res.w_zero, res.saturated};
            msg = sb.check_result(got);
            if (msg != "") report(msg);
        end
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Writes one matrix register while the block is idle.
    task automatic write_reg(logic [7:0] idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        sb.write_reg(idx, value);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one vertex request, then idles at random.
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        vtx.valid    <= 1'b1;
        vtx.vertex_x <= x;
        vtx.vertex_y <= y;
        vtx.vertex_z <= z;
        do @(posedge i_clk); while (!vtx.ready);
        sb.note_vertex(x, y, z);
        if ($urandom_range(99) < send_gap_pct) begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Lets every outstanding vertex drain before touching the matrix.
    task automatic drain();
        vtx.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return 32'h0;
        if (pick < 70) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        if (pick < 80) return 32'h0001_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(1)) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        return $urandom;
    endfunction

    initial begin
        logic [63:0] regval;
        int          phase_items;
        sb             = new();
        mismatches     = 0;
        cycle_count    = 0;
        send_gap_pct   = 6;
        recv_stall_pct = 68;
        i_rst_n        = 1'b0;
        vtx.valid      = 1'b0;
        vtx.vertex_x   = '0;
        vtx.vertex_y   = '0;
        vtx.vertex_z   = '0;
        cfg.valid      = 1'b0;
        cfg.index      = '0;
        cfg.data       = '0;
        res.ready      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity matrix from reset: extremes pass through unchanged.
        send_vertex(32'sh0, 32'sh0, 32'sh0);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, -32'sh1);
        send_vertex(32'hffff_ffff, 32'h1, 32'h5555_aaaa);

        // All-zero matrix: w is zero for every vertex.
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_reg(8'(i), 64'h0);
        send_vertex(32'sh1234_5678, -32'sh10, 32'sh7fff_ffff);
        send_vertex(32'sh0, 32'sh0, 32'sh0);

        // Large scale on x, small w: the outputs clip.
        drain();
        write_reg(0, 64'h7fff_ffff_7fff_ffff);
        write_reg(7, 64'h0000_0001_8000_0000);
        send_vertex(32'sh7fff_ffff, 32'sh0, 32'sh0);
        send_vertex(32'sh8000_0000, 32'sh0, 32'sh0);
        send_vertex(32'sh0, 32'sh0, 32'sh0);

        // Negative w flips signs; w depending on x can cancel to zero.
        drain();
        write_reg(0, 64'h0001_0000_0001_0000);
        write_reg(1, 64'hffff_0000_0000_0000);
        write_reg(7, 64'h0001_0000_0000_0000);
        write_reg(8'hc8, 64'hdead_beef_dead_beef);
        send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0);
        send_vertex(32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000);
        send_vertex(-32'sh0003_0000, 32'sh0, 32'sh0001_0000);

        // Every entry at its most negative and most positive value.
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_reg(8'(i), 64'h8000_0000_8000_0000);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_vertex(32'sh7fff_ffff, 32'sh1, 32'sh0);
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_reg(8'(i), 64'h7fff_ffff_7fff_ffff);
        send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, -32'sh1);

        // Random matrices, random vertices, three idling profiles.
        for (int phase = 0; phase < 11; phase++) begin
            drain();
            if (phase == 4) begin
                send_gap_pct   = 68;
                recv_stall_pct = 6;
            end else if (phase == 8) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                regval = {rand_coef(), rand_coef()};
                if (i == 7 && $urandom_range(3) != 0) regval[63:32] = rand_coef() | 32'h100;
                write_reg(8'(i), regval);
            end
            phase_items = 100;
            for (int n = 0; n < phase_items; n++) begin
                send_vertex(rand_coord(), rand_coord(), rand_coord());
                if (phase == 2 && n == 50) begin
                    vtx.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
        end

        // Wind down.
        vtx.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/hvt_pkg.sv
sv/hvt_if.sv
sv/hvt_mat_regs.sv
sv/hvt_dot.sv
sv/hvt_div.sv
sv/homogeneous_vertex_transform_top.sv
test/tb_top.sv
